// ----- rtl/uarttx_pkg.sv -----
// shared types and constants of the uart transmitter with byte fifo
// no dependencies; used by uart_tx_with_fifo_top and its testbench
package uarttx_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 128;

   localparam int DATA_W     = 8;
   localparam int TICKS_W    = 16;
   localparam int GAP_W      = 4;
   localparam int FILL_OUT_W = 8;
   localparam int POS_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // frame positions: 0..14 gap periods, then start, data, parity, stop
   localparam logic [POS_W-1:0] POS_START  = 5'd16;
   localparam logic [POS_W-1:0] POS_DATA0  = 5'd17;
   localparam logic [POS_W-1:0] POS_DATA7  = 5'd24;
   localparam logic [POS_W-1:0] POS_PARITY = 5'd25;
   localparam logic [POS_W-1:0] POS_STOP   = 5'd26;

   localparam logic [TICKS_W-1:0] BIT_TICKS_RESET = 16'd16;
   localparam logic [GAP_W-1:0]   GAP_BITS_RESET  = 4'd5;

   typedef enum logic [1:0] {
      CSR_BIT_TICKS     = 2'd0,
      CSR_PARITY_ENABLE = 2'd1,
      CSR_IDLE_LEVEL    = 2'd2,
      CSR_GAP_BITS      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  line_level;
      logic                  push_accepted;
      logic [FILL_OUT_W-1:0] fifo_fill;
      logic                  busy_res;
   } result_type;

endpackage

// ----- rtl/uarttx_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
// read-first: a read and a write of one address in one cycle return old data
module uarttx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/uart_tx_with_fifo_top.sv -----
// uart transmitter with byte fifo: top level, bit timer, framing, csr port
// depends on uarttx_pkg and uarttx_ram
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_push_valid, req_data_byte
//  rsp      out        rsp_valid/rsp_ready    rsp_line_level, rsp_push_accepted,
//                                             rsp_fifo_fill, rsp_busy_res
//  csr      in/out     apb psel/penable       csr_paddr, csr_pwdata, csr_prdata
//
// one request is one bit-timer tick, taken every cycle while the skid register is
// empty; the tick is worked out in the cycle it is accepted and its response
// lands in an output register backed by a skid register, so rsp stalls cost
// nothing until both hold a response. the fifo ram has one read port: a pop
// reads the byte, which reaches the shift register before any data bit is sent.
// reset is synchronous; the fifo contents are not cleared (only popped entries
// are ever read), so no clearing pass follows reset.
module uart_tx_with_fifo_top
   import uarttx_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_push_valid,
   input  logic [DATA_W-1:0]     req_data_byte,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_line_level,
   output logic                  rsp_push_accepted,
   output logic [FILL_OUT_W-1:0] rsp_fifo_fill,
   output logic                  rsp_busy_res,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   // configuration registers
   logic [TICKS_W-1:0] bit_ticks_ff;
   logic               parity_enable_ff;
   logic               idle_level_ff;
   logic [GAP_W-1:0]   gap_bits_ff;

   // transmitter and fifo pointer state
   logic [IDX_W-1:0]   read_index_ff, read_index_in;
   logic [IDX_W-1:0]   write_index_ff, write_index_in;
   logic [CNT_W-1:0]   fill_count_ff, fill_count_in;
   logic [DATA_W-1:0]  shift_reg_ff, shift_reg_in;
   logic [POS_W-1:0]   frame_pos_ff, frame_pos_in;
   logic [TICKS_W-1:0] tick_count_ff, tick_count_in;
   logic               sending_ff, sending_in;
   logic               parity_acc_ff, parity_acc_in;
   logic               load_pending_ff, load_pending_in;

   // response buffering
   result_type out_ff, skid_ff, result;
   logic       out_valid_ff, skid_valid_ff;

   logic              accept;
   logic              pop;
   logic              push_ok;
   logic [DATA_W-1:0] shift_cur;
   logic [DATA_W-1:0] ram_rd_data;
   logic [CNT_W-1:0]  fill_after_pop;
   logic [TICKS_W-1:0] period;
   logic              bit_end;
   logic              logical;
   logic              csr_wr;
   csr_index_type     csr_index;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   // ------------------------------------------------------------------
   // csr port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff     <= BIT_TICKS_RESET;
         parity_enable_ff <= 1'b0;
         idle_level_ff    <= 1'b0;
         gap_bits_ff      <= GAP_BITS_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_BIT_TICKS:     bit_ticks_ff     <= csr_pwdata[TICKS_W-1:0];
            CSR_PARITY_ENABLE: parity_enable_ff <= csr_pwdata[0];
            CSR_IDLE_LEVEL:    idle_level_ff    <= csr_pwdata[0];
            CSR_GAP_BITS:      gap_bits_ff      <= csr_pwdata[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_BIT_TICKS:     csr_prdata = CSR_DATA_W'(bit_ticks_ff);
         CSR_PARITY_ENABLE: csr_prdata = CSR_DATA_W'(parity_enable_ff);
         CSR_IDLE_LEVEL:    csr_prdata = CSR_DATA_W'(idle_level_ff);
         CSR_GAP_BITS:      csr_prdata = CSR_DATA_W'(gap_bits_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // fifo storage
   // ------------------------------------------------------------------
   // a pop of a full fifo can meet a push to the same slot; the ram is
   // read-first, so the popped byte is the old one
   uarttx_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (accept && push_ok),
      .wr_addr (write_index_ff),
      .wr_data (req_data_byte),
      .rd_en   (accept && pop),
      .rd_addr (read_index_ff),
      .rd_data (ram_rd_data)
   );

   // byte read on the pop tick is taken from the ram's read register while the load is pending
   assign shift_cur = load_pending_ff ? ram_rd_data : shift_reg_ff;

   // ------------------------------------------------------------------
   // one tick of the transmitter
   // ------------------------------------------------------------------
   assign pop            = !sending_ff && (fill_count_ff != '0);
   assign fill_after_pop = fill_count_ff - CNT_W'(pop);
   assign push_ok        = req_push_valid && (fill_after_pop < CNT_W'(CNT_FULL));
   assign period         = (bit_ticks_ff == '0) ? TICKS_W'(1) : bit_ticks_ff;

   always_comb begin
      logic [POS_W-1:0] pos;
      logic             snd;
      logic [TICKS_W-1:0] tick;
      logic             par;
      snd  = sending_ff || pop;
      pos  = pop ? '0 : frame_pos_ff;
      tick = pop ? '0 : tick_count_ff;
      par  = pop ? 1'b0 : parity_acc_ff;

      // gap no longer than the current position: go straight to start
      if (snd && pos < POS_START && pos >= POS_W'(gap_bits_ff)) begin
         pos = POS_START;
      end

      priority if (pos < POS_START) begin
         logical = 1'b1;
      end else if (pos == POS_START) begin
         logical = 1'b0;
      end else if (pos <= POS_DATA7) begin
         logical = shift_cur[0];
      end else if (pos == POS_PARITY) begin
         logical = ~par;
      end else begin
         logical = 1'b1;
      end

      result.line_level    = snd ? (logical ^ ~idle_level_ff) : idle_level_ff;
      result.busy_res      = snd;
      result.push_accepted = push_ok;
      result.fifo_fill     = FILL_OUT_W'(fill_after_pop + CNT_W'(push_ok));

      bit_end       = ({1'b0, tick} + 17'd1) >= {1'b0, period};
      sending_in    = snd;
      frame_pos_in  = pos;
      tick_count_in = tick;
      parity_acc_in = par;
      shift_reg_in  = shift_cur;

      if (snd) begin
         if (bit_end) begin
            tick_count_in = '0;
            priority if (pos < POS_START) begin
               frame_pos_in = pos + POS_W'(1);
               if (frame_pos_in >= POS_W'(gap_bits_ff)) begin
                  frame_pos_in = POS_START;
               end
            end else if (pos == POS_START) begin
               frame_pos_in = POS_DATA0;
            end else if (pos <= POS_DATA7) begin
               parity_acc_in = par ^ shift_cur[0];
               shift_reg_in  = {1'b0, shift_cur[DATA_W-1:1]};
               if (pos == POS_DATA7) begin
                  frame_pos_in = parity_enable_ff ? POS_PARITY : POS_STOP;
               end else begin
                  frame_pos_in = pos + POS_W'(1);
               end
            end else if (pos == POS_PARITY) begin
               frame_pos_in = POS_STOP;
            end else begin
               sending_in   = 1'b0;
               frame_pos_in = '0;
            end
         end else begin
            tick_count_in = tick + TICKS_W'(1);
         end
      end

      read_index_in  = read_index_ff;
      if (pop) begin
         read_index_in = (read_index_ff == IDX_LAST) ? '0 : read_index_ff + IDX_W'(1);
      end
      write_index_in = write_index_ff;
      if (push_ok) begin
         write_index_in = (write_index_ff == IDX_LAST) ? '0 : write_index_ff + IDX_W'(1);
      end
      fill_count_in   = fill_after_pop + CNT_W'(push_ok);
      load_pending_in = pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff   <= '0;
         write_index_ff  <= '0;
         fill_count_ff   <= '0;
         shift_reg_ff    <= '0;
         frame_pos_ff    <= '0;
         tick_count_ff   <= '0;
         sending_ff      <= 1'b0;
         parity_acc_ff   <= 1'b0;
         load_pending_ff <= 1'b0;
      end else if (accept) begin
         read_index_ff   <= read_index_in;
         write_index_ff  <= write_index_in;
         fill_count_ff   <= fill_count_in;
         shift_reg_ff    <= shift_reg_in;
         frame_pos_ff    <= frame_pos_in;
         tick_count_ff   <= tick_count_in;
         sending_ff      <= sending_in;
         parity_acc_ff   <= parity_acc_in;
         load_pending_ff <= load_pending_in;
      end else if (load_pending_ff) begin
         // no tick this cycle: park the fetched byte in the shift register
         shift_reg_ff    <= ram_rd_data;
         load_pending_ff <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // response register and skid stage
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         // output register frees up; skid holds the older response
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_line_level    = out_ff.line_level;
   assign rsp_push_accepted = out_ff.push_accepted;
   assign rsp_fifo_fill     = out_ff.fifo_fill;
   assign rsp_busy_res      = out_ff.busy_res;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_FULL)
      else $error("fifo fill count above depth");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a response while output register is empty");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (frame_pos_ff == '0 && tick_count_ff == '0 && !load_pending_ff))
      else $error("transmitter idle with frame state left over");

   a_pop_fetch: assert property (@(posedge clock) disable iff (reset)
      (accept && pop) |=> (sending_ff && load_pending_ff))
      else $error("pop did not start a frame with a pending fifo read");
`endif

endmodule

// ----- dv/uart_tx_with_fifo_top_tb.sv -----
// testbench for uart_tx_with_fifo_top: ticks drive the bit timer, each response is
// compared with a cycle-accurate line predictor kept in this file
// depends on uarttx_pkg and the uart_tx_with_fifo_top rtl
`timescale 1ns / 1ps

module uart_tx_with_fifo_top_tb;
   import uarttx_pkg::*;

   localparam int FIFO_DEPTH  = FIFO_DEPTH_DEFAULT;
   localparam int HOLD_CYCLES = 300;      // long receiver hold-off for the overflow test
   localparam int CYCLE_LIMIT = 100000;   // far above the slowest legal run

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic              req_push_valid = 1'b0;
   logic [DATA_W-1:0] req_data_byte  = '0;

   // response channel
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_line_level;
   logic                  rsp_push_accepted;
   logic [FILL_OUT_W-1:0] rsp_fifo_fill;
   logic                  rsp_busy_res;

   // apb configuration port
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // flow control knobs, percent of cycles spent idle on each side
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;   // bumped by a test to ask the receiver for a long hold-off
   int error_count   = 0;
   int cycle_count   = 0;

   // predictor copy of the registers, reset values of the block
   logic [TICKS_W-1:0] cfg_bit_ticks  = BIT_TICKS_RESET;
   logic               cfg_parity_en  = 1'b0;
   logic               cfg_idle_level = 1'b0;
   logic [GAP_W-1:0]   cfg_gap_bits   = GAP_BITS_RESET;

   // predictor copy of the transmitter state
   logic [DATA_W-1:0]  queued_bytes[$];
   logic [DATA_W-1:0]  tx_shift  = '0;
   logic [POS_W-1:0]   tx_pos    = '0;
   logic [TICKS_W-1:0] tx_ticks  = '0;
   logic               tx_active = 1'b0;
   logic               tx_parity = 1'b0;

   // line samples still owed by the block, oldest first
   result_type expected_line_ticks[$];

   uart_tx_with_fifo_top #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_push_valid   (req_push_valid),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_level   (rsp_line_level),
      .rsp_push_accepted(rsp_push_accepted),
      .rsp_fifo_fill    (rsp_fifo_fill),
      .rsp_busy_res     (rsp_busy_res),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 125 MHz clock
   initial begin
      forever #4 clock = ~clock;
   end

   // one bit-timer tick of the transmitter: pop, drive the line, advance, then queue
   function automatic void predict_line_tick(input logic push, input logic [DATA_W-1:0] data);
      result_type sample;
      logic [TICKS_W:0] period;
      logic logical;
      period  = (cfg_bit_ticks == '0) ? 1 : {1'b0, cfg_bit_ticks};
      logical = 1'b1;
      // idle transmitter picks up the oldest byte in this same tick
      if (!tx_active && queued_bytes.size() > 0) begin
         tx_shift  = queued_bytes.pop_front();
         tx_active = 1'b1;
         tx_pos    = '0;
         tx_ticks  = '0;
         tx_parity = 1'b0;
      end
      // gap already long enough (zero gap, or gap shortened mid-gap): go to start now
      if (tx_active && tx_pos < POS_START && tx_pos >= cfg_gap_bits)
         tx_pos = POS_START;
      sample.busy_res = tx_active;
      if (tx_active) begin
         if (tx_pos == POS_START)
            logical = 1'b0;
         else if (tx_pos >= POS_DATA0 && tx_pos <= POS_DATA7)
            logical = tx_shift[0];
         else if (tx_pos == POS_PARITY)
            logical = ~tx_parity;
         // gap and stop stay at the logical one
         sample.line_level = logical ^ ~cfg_idle_level;
      end else begin
         sample.line_level = cfg_idle_level;
      end
      // bit timer
      if (tx_active) begin
         if ({1'b0, tx_ticks} + 1 >= period) begin
            tx_ticks = '0;
            if (tx_pos < POS_START) begin
               tx_pos = tx_pos + 1'b1;
               if (tx_pos >= cfg_gap_bits)
                  tx_pos = POS_START;
            end else if (tx_pos == POS_START) begin
               tx_pos = POS_DATA0;
            end else if (tx_pos <= POS_DATA7) begin
               tx_parity = tx_parity ^ tx_shift[0];
               tx_shift  = tx_shift >> 1;
               // parity enable is looked at only as the last data bit ends
               if (tx_pos == POS_DATA7)
                  tx_pos = cfg_parity_en ? POS_PARITY : POS_STOP;
               else
                  tx_pos = tx_pos + 1'b1;
            end else if (tx_pos == POS_PARITY) begin
               tx_pos = POS_STOP;
            end else begin
               tx_active = 1'b0;
               tx_pos    = '0;
            end
         end else begin
            tx_ticks = tx_ticks + 1'b1;
         end
      end
      // the pushed byte lands last, so a push into an empty fifo starts next tick
      sample.push_accepted = 1'b0;
      if (push && queued_bytes.size() < FIFO_DEPTH) begin
         queued_bytes.push_back(data);
         sample.push_accepted = 1'b1;
      end
      sample.fifo_fill = FILL_OUT_W'(queued_bytes.size());
      expected_line_ticks.push_back(sample);
   endfunction

   task automatic check_field(input string field, input logic [CSR_DATA_W-1:0] want,
                              input logic [CSR_DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   // offer one tick request, with random idle cycles in front, and predict it on acceptance
   task automatic send_tick(input logic push, input logic [DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_push_valid <= push;
      req_data_byte  <= data;
      do @(posedge clock); while (!req_ready);
      predict_line_tick(push, data);
   endtask

   task automatic send_random_ticks(input int count, input int push_pct);
      repeat (count) send_tick($urandom_range(99) < push_pct, DATA_W'($urandom));
   endtask

   // stop offering and wait for every owed response; the block does not run without ticks
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (expected_line_ticks.size() != 0) @(posedge clock);
   endtask

   // apb write then read-back; only done with nothing in flight
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] stored;
      finish_phase();
      stored = '0;
      case (idx)
         CSR_BIT_TICKS: begin
            cfg_bit_ticks = value[TICKS_W-1:0];
            stored        = CSR_DATA_W'(cfg_bit_ticks);
         end
         CSR_PARITY_ENABLE: begin
            cfg_parity_en = value[0];
            stored        = CSR_DATA_W'(cfg_parity_en);
         end
         CSR_IDLE_LEVEL: begin
            cfg_idle_level = value[0];
            stored         = CSR_DATA_W'(cfg_idle_level);
         end
         CSR_GAP_BITS: begin
            cfg_gap_bits = value[GAP_W-1:0];
            stored       = CSR_DATA_W'(cfg_gap_bits);
         end
      endcase
      // write: setup then access
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read back from the same address
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("csr readback", stored, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // first frame at reset settings: push into an empty fifo, start on the next tick
   task automatic test_reset_frame();
      send_tick(1'b1, 8'h00);
      send_tick(1'b0, 8'hFF);
   endtask

   // fastest timer, then shorten a long gap while the line is in it
   task automatic test_gap_shortened();
      write_reg(CSR_BIT_TICKS, 32'd0);   // zero acts as one tick per bit
      write_reg(CSR_GAP_BITS, 32'd15);
      repeat (3) send_tick(1'b0, 8'h00);
      write_reg(CSR_GAP_BITS, 32'd2);    // gap ends at once, start bit this tick
      send_tick(1'b1, 8'hFF);
   endtask

   // turn parity on halfway through the data bits; it counts at the last data bit
   task automatic test_parity_mid_frame();
      send_tick(1'b1, 8'h80);
      send_tick(1'b1, 8'h01);
      send_tick(1'b0, 8'hAA);
      send_tick(1'b1, 8'h7F);
      write_reg(CSR_PARITY_ENABLE, 32'd1);
      repeat (6) send_tick(1'b0, 8'h55);
   endtask

   // normal polarity, no gap, next queued byte right after the stop bit
   task automatic test_back_to_back();
      write_reg(CSR_IDLE_LEVEL, 32'd1);
      write_reg(CSR_GAP_BITS, 32'd0);
      repeat (5) send_tick(1'b1, 8'hFE);
   endtask

   // random traffic over a spread of framings and both idling patterns
   task automatic test_random_framing();
      send_idle_pct = 6;
      recv_idle_pct = 54;
      write_reg(CSR_BIT_TICKS, 32'd1);
      write_reg(CSR_GAP_BITS, $urandom_range(3));
      send_random_ticks(200, 25);
      send_idle_pct = 54;
      recv_idle_pct = 6;
      write_reg(CSR_BIT_TICKS, $urandom_range(4, 2));
      write_reg(CSR_PARITY_ENABLE, 32'd0);
      write_reg(CSR_IDLE_LEVEL, 32'd0);
      write_reg(CSR_GAP_BITS, $urandom_range(15));
      send_random_ticks(200, 15);
      send_idle_pct = 0;
      recv_idle_pct = 0;
   endtask

   // longest bit period and gap: the line barely moves
   task automatic test_slowest_rate();
      write_reg(CSR_BIT_TICKS, 32'hFFFF);
      write_reg(CSR_GAP_BITS, 32'd15);
      send_random_ticks(30, 50);
   endtask

   // one tick per bit with parity and no gap, frames run back to back
   task automatic test_fastest_rate();
      write_reg(CSR_BIT_TICKS, 32'd0);
      write_reg(CSR_GAP_BITS, 32'd0);
      write_reg(CSR_PARITY_ENABLE, 32'd1);
      write_reg(CSR_IDLE_LEVEL, 32'd1);
      send_random_ticks(250, 8);
   endtask

   // slow line, near-constant pushes: fifo fills and refuses; receiver holds off meanwhile
   task automatic test_fifo_overflow();
      write_reg(CSR_BIT_TICKS, 32'd100);
      write_reg(CSR_GAP_BITS, 32'd15);
      write_reg(CSR_PARITY_ENABLE, 32'd0);
      hold_requests++;
      send_random_ticks(170, 95);
   endtask

   // receiver: random ready, or a long hold-off when a test asks for one
   initial begin : response_sink
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // response checker: every accepted response against the oldest predicted tick
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_line_ticks.size() == 0) begin
            $error("response with no tick outstanding");
            error_count++;
         end else begin
            want = expected_line_ticks.pop_front();
            check_field("line_level", CSR_DATA_W'(want.line_level),
                        CSR_DATA_W'(rsp_line_level));
            check_field("push_accepted", CSR_DATA_W'(want.push_accepted),
                        CSR_DATA_W'(rsp_push_accepted));
            check_field("fifo_fill", CSR_DATA_W'(want.fifo_fill),
                        CSR_DATA_W'(rsp_fifo_fill));
            check_field("busy_res", CSR_DATA_W'(want.busy_res),
                        CSR_DATA_W'(rsp_busy_res));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("uart_tx_with_fifo_top verification failed");
      $finish;
   end

   // test sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_frame();
      test_gap_shortened();
      test_parity_mid_frame();
      test_back_to_back();
      test_random_framing();
      test_slowest_rate();
      test_fastest_rate();
      test_fifo_overflow();
      finish_phase();
      // output register plus skid register, with margin
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_line_ticks.size() == 0)
         $display("uart_tx_with_fifo_top verification clean");
      else
         $display("uart_tx_with_fifo_top verification failed");
      $finish;
   end

endmodule
